@@ hdl/tpr_pkg.sv @@
// ----------------------------------------------------------------------------
// tpr_pkg
// types and constants shared by the transport stream pes reassembler
// ----------------------------------------------------------------------------
package tpr_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int COUNT_W      = 17;
    localparam int LEN_W        = 16;
    localparam int PID_W        = 13;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // packet status codes
    localparam logic [2:0] ST_FOREIGN  = 3'd0;
    localparam logic [2:0] ST_LOST     = 3'd1;
    localparam logic [2:0] ST_STARTED  = 3'd2;
    localparam logic [2:0] ST_CONTINUE = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;

    typedef struct packed {
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic               status_valid;
        logic [2:0]         packet_status;
        logic [COUNT_W-1:0] assembled_count;
    } t_result;

endpackage

@@ hdl/tpr_if.sv @@
// ----------------------------------------------------------------------------
// tpr channel interfaces
// valid/ready channels for transport bytes, results and configuration
// ----------------------------------------------------------------------------
interface tpr_ts_if;
    logic       valid;
    logic       ready;
    logic [7:0] ts_byte;
    logic       packet_first;

    modport source (output valid, output ts_byte, output packet_first, input ready);
    modport sink   (input valid, input ts_byte, input packet_first, output ready);
endinterface

interface tpr_res_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        status_valid;
    logic [2:0]  packet_status;
    logic [16:0] assembled_count;

    modport source (output valid, output payload_valid, output payload_byte,
                    output status_valid, output packet_status,
                    output assembled_count, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input status_valid, input packet_status,
                    input assembled_count, output ready);
endinterface

interface tpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] wanted_pid;

    modport source (output valid, output wanted_pid, input ready);
    modport sink   (input valid, input wanted_pid, output ready);
endinterface

@@ hdl/tpr_core.sv @@
// ----------------------------------------------------------------------------
// tpr_core
// header parse, continuity check, payload forwarding and pes length tracking
// ----------------------------------------------------------------------------
module tpr_core
    import tpr_pkg::*;
#(
    parameter int PACKET_BYTES = 188
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_write,
    input  logic [PID_W-1:0] i_cfg_pid,
    input  logic             i_accept,
    input  logic [7:0]       i_ts_byte,
    input  logic             i_packet_first,
    output t_result          o_result
);

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HEADER_BYTES);

    logic [PID_W-1:0] r_wanted_pid;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [23:0]      r_hdr, n_hdr;
    logic             r_rejected, n_rejected;
    logic [7:0]       r_af_len, n_af_len;
    logic [3:0]       r_prev_cc, n_prev_cc;
    logic             r_cc_known, n_cc_known;
    logic             r_assembling, n_assembling;
    logic [LEN_W-1:0] r_exp_len, n_exp_len;
    logic [COUNT_W-1:0] r_total, n_total;
    logic             r_capturing, n_capturing;

    logic [POS_W-1:0] pos;
    logic [8:0]       first_payload;
    logic             is_payload;
    logic             length_met;
    logic [PID_W-1:0] hdr_pid;
    logic             hdr_start;
    logic [1:0]       hdr_afc;
    logic [3:0]       hdr_cc;

    always_comb begin
        pos          = i_packet_first ? '0 : r_pos;
        n_hdr        = r_hdr;
        n_rejected   = r_rejected;
        n_af_len     = r_af_len;
        n_prev_cc    = r_prev_cc;
        n_cc_known   = r_cc_known;
        n_assembling = r_assembling;
        n_exp_len    = r_exp_len;
        n_total      = r_total;
        n_capturing  = r_capturing;
        first_payload = 9'(HEADER_BYTES);
        is_payload   = 1'b0;

        o_result = '0;

        if (pos == '0) begin
            n_rejected = 1'b1;
        end else if (pos < HDR_POS) begin
            n_hdr = {r_hdr[15:0], i_ts_byte};
        end

        hdr_pid   = n_hdr[20:8];
        hdr_start = n_hdr[22];
        hdr_afc   = n_hdr[5:4];
        hdr_cc    = n_hdr[3:0];

        if (pos == HDR_LAST) begin
            if (hdr_pid != r_wanted_pid) begin
                n_rejected = 1'b1;
            end else if (r_cc_known && hdr_cc != (r_prev_cc + 4'd1)) begin
                n_rejected = 1'b1;
            end else begin
                n_rejected = 1'b0;
                n_prev_cc  = hdr_cc;
                n_cc_known = 1'b1;
                n_af_len   = '0;
                if (hdr_start && !r_assembling) begin
                    n_total     = '0;
                    n_exp_len   = '0;
                    n_capturing = 1'b1;
                end
            end
        end

        if (pos >= HDR_POS && !r_rejected) begin
            if (hdr_afc > 2'd1) begin
                if (pos == HDR_POS) begin
                    n_af_len = i_ts_byte;
                end
                first_payload = 9'(HEADER_BYTES + 1) + {1'b0, n_af_len};
                is_payload = (pos > HDR_POS) && ({{(9-POS_W){1'b0}}, pos} >= first_payload);
            end else begin
                is_payload = 1'b1;
            end
            if (is_payload) begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_ts_byte;
                if (r_capturing) begin
                    if (r_total == COUNT_W'(4)) begin
                        n_exp_len = {i_ts_byte, 8'h00};
                    end else if (r_total == COUNT_W'(5)) begin
                        n_exp_len   = {r_exp_len[15:8], i_ts_byte};
                        n_capturing = 1'b0;
                    end
                end
                if (r_total < COUNT_MAX) begin
                    n_total = r_total + COUNT_W'(1);
                end
            end
        end

        length_met = (n_exp_len != '0) && (n_total >= {1'b0, n_exp_len});

        if (pos == LAST_POS) begin
            o_result.status_valid = 1'b1;
            if (n_rejected) begin
                o_result.packet_status = (hdr_pid != r_wanted_pid) ? ST_FOREIGN : ST_LOST;
            end else if (hdr_start) begin
                if (n_assembling) begin
                    n_assembling = 1'b0;
                    o_result.packet_status = ST_FINISHED;
                end else if (length_met) begin
                    o_result.packet_status = ST_FINISHED;
                end else begin
                    n_assembling = 1'b1;
                    o_result.packet_status = ST_STARTED;
                end
            end else if (length_met) begin
                n_assembling = 1'b0;
                o_result.packet_status = ST_FINISHED;
            end else begin
                o_result.packet_status = ST_CONTINUE;
            end
            n_pos = '0;
        end else begin
            n_pos = pos + POS_W'(1);
        end

        o_result.assembled_count = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_pid <= '0;
            r_pos        <= '0;
            r_hdr        <= '0;
            r_rejected   <= 1'b0;
            r_af_len     <= '0;
            r_prev_cc    <= '0;
            r_cc_known   <= 1'b0;
            r_assembling <= 1'b0;
            r_exp_len    <= '0;
            r_total      <= '0;
            r_capturing  <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_wanted_pid <= i_cfg_pid;
            end
            if (i_accept) begin
                r_pos        <= n_pos;
                r_hdr        <= n_hdr;
                r_rejected   <= n_rejected;
                r_af_len     <= n_af_len;
                r_prev_cc    <= n_prev_cc;
                r_cc_known   <= n_cc_known;
                r_assembling <= n_assembling;
                r_exp_len    <= n_exp_len;
                r_total      <= n_total;
                r_capturing  <= n_capturing;
            end
        end
    end

endmodule

@@ hdl/tpr_out_buf.sv @@
// ----------------------------------------------------------------------------
// tpr_out_buf
// result register with a skid entry, keeps input ready off the output ready path
// ----------------------------------------------------------------------------
module tpr_out_buf
    import tpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign pop     = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

@@ hdl/ts_pes_reassembler_unit.sv @@
// ----------------------------------------------------------------------------
// ts_pes_reassembler_unit
// reassembles the pes payload of one transport stream pid, byte by byte
// ----------------------------------------------------------------------------
// an accepted byte's result is registered in the output register or skid entry
// throughput: one byte per cycle while the skid entry is free, set by the single
//   parse stage; a two-entry buffer keeps requests flowing while one result waits
// reset: synchronous active-low i_rst_n clears parse state, wanted pid and buffer
// ----------------------------------------------------------------------------
module ts_pes_reassembler_unit
    import tpr_pkg::*;
#(
    parameter int PACKET_BYTES = 188
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    tpr_cfg_if.sink i_cfg,
    tpr_ts_if.sink  i_ts,
    tpr_res_if.source o_res
);

    logic    in_ready;
    logic    accept;
    t_result core_result;
    t_result buf_result;

    // configuration is always taken, pid applies to the next header decision
    assign i_cfg.ready = 1'b1;

    // a byte request is taken whenever the skid entry is free
    assign i_ts.ready = in_ready;
    assign accept     = i_ts.valid && in_ready;

    // parse stage: packet position, header latch, continuity and pes length
    tpr_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg.valid),
        .i_cfg_pid      (i_cfg.wanted_pid),
        .i_accept       (accept),
        .i_ts_byte      (i_ts.ts_byte),
        .i_packet_first (i_ts.packet_first),
        .o_result       (core_result)
    );

    // result register plus skid entry toward the consumer
    tpr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_result),
        .o_ready (in_ready),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (buf_result)
    );

    // unpack the result request onto the channel
    assign o_res.payload_valid   = buf_result.payload_valid;
    assign o_res.payload_byte    = buf_result.payload_byte;
    assign o_res.status_valid    = buf_result.status_valid;
    assign o_res.packet_status   = buf_result.packet_status;
    assign o_res.assembled_count = buf_result.assembled_count;

endmodule
